// ===== hdl/set_assoc_lru_cache_tag_engine_macros.svh =====
// Assertion macros used by the checker file.
`ifndef SET_ASSOC_LRU_CACHE_TAG_ENGINE_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_TAG_ENGINE_MACROS_SVH
// Same-cycle implication, disabled during reset.
`define SALC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cache tag engine check failed");
// Next-cycle implication, disabled during reset.
`define SALC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cache tag engine check failed");
`endif

// ===== hdl/salc_pkg.sv =====
// Shared types and constants of the cache tag engine.
package salc_pkg;
  localparam int MAX_SETS   = 256;
  localparam int MAX_WAYS   = 4;
  localparam int SET_W      = $clog2(MAX_SETS);
  localparam int ROW_AW     = SET_W + 1;
  localparam int ROWS       = 2 * MAX_SETS;
  localparam int WAY_W      = $clog2(MAX_WAYS);
  localparam int FILL_W     = WAY_W + 1;
  localparam int ADDR_W     = 32;
  localparam int TAG_W      = ADDR_W - 2;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_FETCH = 2'd2;
  localparam logic [1:0] KIND_FLUSH = 2'd3;

  localparam logic [2:0] REG_SPLIT  = 3'd0;
  localparam logic [2:0] REG_ISETS  = 3'd1;
  localparam logic [2:0] REG_DSETS  = 3'd2;
  localparam logic [2:0] REG_WAYS   = 3'd3;
  localparam logic [2:0] REG_OFFSET = 3'd4;
  localparam logic [2:0] REG_WB     = 3'd5;
  localparam logic [2:0] REG_WA     = 3'd6;

  // One memory row holds a whole set.
  typedef struct packed {
    logic [MAX_WAYS-1:0][TAG_W-1:0] tag;
    logic [MAX_WAYS-1:0]            dirty;
    logic [MAX_WAYS-1:0][1:0]       age;
    logic [FILL_W-1:0]              fill;
  } row_t;

  typedef struct packed {
    logic        hit;
    logic        replaced;
    logic [4:0]  fetch_words;
    logic [15:0] copy_back_words;
    logic        we;
  } lookup_res_t;

  typedef struct packed {
    logic [FILL_W-1:0] ways;
    logic [4:0]        wpb;
    logic              write_back;
    logic              write_allocate;
  } policy_t;
endpackage

// ===== hdl/salc_row_ram.sv =====
// Set row memory: one write port, one registered read port.
module salc_row_ram (
  input  logic                      clk,
  input  logic                      re,
  input  logic [salc_pkg::ROW_AW-1:0] raddr,
  output salc_pkg::row_t            rdata,
  input  logic                      we,
  input  logic [salc_pkg::ROW_AW-1:0] waddr,
  input  salc_pkg::row_t            wdata
);
  import salc_pkg::*;

  row_t mem [ROWS];

  // Read-first on a shared address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== hdl/salc_update.sv =====
// Hit search, victim choice and LRU update of one set row.
module salc_update (
  input  salc_pkg::row_t              row,
  input  logic [salc_pkg::TAG_W-1:0]  tag,
  input  logic                        store,
  input  salc_pkg::policy_t           pol,
  output salc_pkg::row_t              nrow,
  output salc_pkg::lookup_res_t       res
);
  import salc_pkg::*;

  logic [FILL_W-1:0] f, nf;
  logic              hit;
  logic [WAY_W-1:0]  hw, vw, way;
  logic [1:0]        a;

  // Search valid lines, lowest way first; pick the first oldest line.
  always_comb begin
    f   = (row.fill > FILL_W'(MAX_WAYS)) ? FILL_W'(MAX_WAYS) : row.fill;
    hit = 1'b0;
    hw  = '0;
    vw  = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (FILL_W'(i) < f && !hit && row.tag[i] == tag) begin
        hit = 1'b1;
        hw  = WAY_W'(i);
      end
    end
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (FILL_W'(i) < f && row.age[i] > row.age[vw]) begin
        vw = WAY_W'(i);
      end
    end
  end

  // Build the written-back row and the result.
  always_comb begin
    nrow = row;
    res  = '0;
    way  = '0;
    nf   = f;
    a    = '0;
    if (hit) begin
      way    = hw;
      a      = row.age[hw];
      res.hit = 1'b1;
      res.we  = 1'b1;
    end else if (store && !pol.write_allocate) begin
      res.copy_back_words = 16'd1;
    end else begin
      res.we          = 1'b1;
      res.fetch_words = pol.wpb;
      if (f < pol.ways) begin
        way = WAY_W'(f);
        nf  = f + FILL_W'(1);
        a   = 2'(f);
      end else begin
        way          = vw;
        a            = row.age[vw];
        res.replaced = 1'b1;
        if (row.dirty[vw]) begin
          res.copy_back_words = {11'd0, pol.wpb};
        end
      end
    end
    if (res.we) begin
      for (int i = 0; i < MAX_WAYS; i++) begin
        if (FILL_W'(i) < nf && WAY_W'(i) != way && row.age[i] < a) begin
          nrow.age[i] = row.age[i] + 2'd1;
        end
      end
      nrow.age[way] = 2'd0;
      nrow.fill     = nf;
      if (!hit) begin
        nrow.tag[way]   = tag;
        nrow.dirty[way] = 1'b0;
      end
      if (store) begin
        if (pol.write_back) begin
          nrow.dirty[way] = 1'b1;
        end else begin
          res.copy_back_words = res.copy_back_words + 16'd1;
        end
      end
    end
  end
endmodule

// ===== hdl/set_assoc_lru_cache_tag_engine.sv =====
// Top level of the set-associative cache tag and LRU engine.
// An access reads the set row from the row memory in the cycle the transaction
// is accepted; in the look state, once the output register is free, the row is
// updated and written back and the result is loaded into the output register. A
// flush sweeps all 512 set rows of both regions, one row per cycle. After reset
// the same sweep clears the memory before the first transaction is taken;
// configuration writes are taken throughout.
module set_assoc_lru_cache_tag_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic        out_replaced,
  output logic [4:0]  out_fetch_words,
  output logic [15:0] out_copy_back_words,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import salc_pkg::*;

  typedef enum logic [2:0] {ST_INIT, ST_IDLE, ST_LOOK, ST_FLUSH, ST_FOUT} state_t;

  state_t           state_r;
  logic [ROW_AW:0]  cnt_r;
  logic             fl_v_r;
  logic [15:0]      acc_r;
  logic [ROW_AW-1:0] row_r;
  logic [TAG_W-1:0] tag_r;
  logic             store_r;

  logic        split_r, wb_r, wa_r;
  logic [3:0]  isb_r, dsb_r;
  logic [2:0]  ways_r, obits_r;

  logic        out_hit_r, out_repl_r, out_valid_r;
  logic [4:0]  out_fetch_r;
  logic [15:0] out_copy_r;

  logic [2:0]  obc;
  logic [3:0]  sb, sb_raw;
  logic [SET_W-1:0] set_idx;
  logic [8:0]  set_mask;
  logic        region;
  logic [ROW_AW-1:0] in_row;
  logic [TAG_W-1:0]  in_tag;
  policy_t     pol;

  logic              ram_re, ram_we;
  logic [ROW_AW-1:0] ram_raddr, ram_waddr;
  row_t              ram_rdata, ram_wdata, upd_row;
  lookup_res_t       res;
  logic [2:0]        dcount;
  logic [15:0]       contrib;
  logic              out_free, in_acc, out_load;

  // Configuration port.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      split_r <= 1'b0; isb_r <= 4'd6; dsb_r <= 4'd6; ways_r <= 3'd1;
      obits_r <= 3'd2; wb_r <= 1'b1; wa_r <= 1'b1;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_SPLIT:  split_r <= pwdata[0];
        REG_ISETS:  isb_r   <= pwdata[3:0];
        REG_DSETS:  dsb_r   <= pwdata[3:0];
        REG_WAYS:   ways_r  <= pwdata[2:0];
        REG_OFFSET: obits_r <= pwdata[2:0];
        REG_WB:     wb_r    <= pwdata[0];
        REG_WA:     wa_r    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_SPLIT:  prdata = {31'd0, split_r};
      REG_ISETS:  prdata = {28'd0, isb_r};
      REG_DSETS:  prdata = {28'd0, dsb_r};
      REG_WAYS:   prdata = {29'd0, ways_r};
      REG_OFFSET: prdata = {29'd0, obits_r};
      REG_WB:     prdata = {31'd0, wb_r};
      REG_WA:     prdata = {31'd0, wa_r};
      default:    prdata = 32'd0;
    endcase
  end

  // Saturate geometry and split the incoming address.
  always_comb begin
    obc = (obits_r < 3'd2) ? 3'd2 : ((obits_r > 3'd6) ? 3'd6 : obits_r);
    pol.wpb = 5'd1 << (obc - 3'd2);
    pol.ways = (ways_r == 3'd0) ? FILL_W'(1) :
               ((ways_r > 3'(MAX_WAYS)) ? FILL_W'(MAX_WAYS) : FILL_W'(ways_r));
    pol.write_back     = wb_r;
    pol.write_allocate = wa_r;
    region   = (in_kind == KIND_FETCH) ? 1'b0 : split_r;
    sb_raw   = region ? dsb_r : isb_r;
    sb       = (sb_raw > 4'(SET_W)) ? 4'(SET_W) : sb_raw;
    set_mask = (9'd1 << sb) - 9'd1;
    set_idx  = SET_W'(in_address >> obc) & set_mask[SET_W-1:0];
    in_tag   = TAG_W'(in_address >> ({1'b0, obc} + sb));
    in_row   = {region, set_idx};
  end

  salc_update u_update (
    .row   (ram_rdata),
    .tag   (tag_r),
    .store (store_r),
    .pol   (pol),
    .nrow  (upd_row),
    .res   (res)
  );

  // Dirty words of one row during a flush.
  always_comb begin
    dcount = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (FILL_W'(i) < ram_rdata.fill && ram_rdata.dirty[i]) begin
        dcount = dcount + 3'd1;
      end
    end
    contrib = 16'(dcount) << (obc - 3'd2);
  end

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_load = ((state_r == ST_LOOK) || (state_r == ST_FOUT)) && out_free;

  // Memory port steering.
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = in_row;
    ram_we    = 1'b0;
    ram_waddr = row_r;
    ram_wdata = upd_row;
    case (state_r)
      ST_IDLE: ram_re = in_acc && in_kind != KIND_FLUSH;
      ST_LOOK: ram_we = out_free && res.we;
      ST_INIT, ST_FLUSH: begin
        ram_re    = !cnt_r[ROW_AW];
        ram_we    = !cnt_r[ROW_AW];
        ram_raddr = cnt_r[ROW_AW-1:0];
        ram_waddr = cnt_r[ROW_AW-1:0];
        ram_wdata = '0;
      end
      default: ;
    endcase
  end

  salc_row_ram u_ram (
    .clk   (clk),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata)
  );

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      fl_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_INIT: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r[ROW_AW]) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            row_r   <= in_row;
            tag_r   <= in_tag;
            store_r <= (in_kind == KIND_WRITE);
            cnt_r   <= '0;
            acc_r   <= '0;
            fl_v_r  <= 1'b0;
            state_r <= (in_kind == KIND_FLUSH) ? ST_FLUSH : ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_hit_r   <= res.hit;
            out_repl_r  <= res.replaced;
            out_fetch_r <= res.fetch_words;
            out_copy_r  <= res.copy_back_words;
            state_r     <= ST_IDLE;
          end
        end
        ST_FLUSH: begin
          if (fl_v_r) begin
            acc_r <= acc_r + contrib;
          end
          fl_v_r <= !cnt_r[ROW_AW];
          if (cnt_r[ROW_AW]) begin
            state_r <= ST_FOUT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_FOUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_hit_r   <= 1'b0;
            out_repl_r  <= 1'b0;
            out_fetch_r <= 5'd0;
            out_copy_r  <= acc_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_hit             = out_hit_r;
  assign out_replaced        = out_repl_r;
  assign out_fetch_words     = out_fetch_r;
  assign out_copy_back_words = out_copy_r;
endmodule

// ===== hdl/salc_checker.sv =====
// Port-level checks of the cache tag engine and their binding.
`include "set_assoc_lru_cache_tag_engine_macros.svh"
module salc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_hit,
  input logic        out_replaced,
  input logic [4:0]  out_fetch_words,
  input logic        pready
);
  `SALC_ASSERT_NOW(a_pready_high, 1'b1, pready)
  `SALC_ASSERT_NOW(a_hit_no_evict, out_valid && out_hit, !out_replaced && out_fetch_words == 5'd0)
  `SALC_ASSERT_NOW(a_evict_fetches, out_valid && out_replaced, out_fetch_words != 5'd0)
  `SALC_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
endmodule

bind set_assoc_lru_cache_tag_engine salc_checker u_salc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_hit         (out_hit),
  .out_replaced    (out_replaced),
  .out_fetch_words (out_fetch_words),
  .pready          (pready)
);
